[rtl/pidc_pkg.sv]
// Shared constants, opcodes and register indexes of the dual-mode PID controller.
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 16;
  localparam int LIMIT_W        = 16;
  localparam int INTEG_W        = 40;
  localparam int DRIVE_W        = 24;
  localparam int CFG_IDX_W      = 3;

  localparam logic signed [LIMIT_W-1:0] UPPER_RST = 16'sd100;
  localparam logic signed [LIMIT_W-1:0] LOWER_RST = -16'sd100;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic {
    MODE_POSITION    = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_TARGET      = 3'd3,
    REG_UPPER_LIMIT = 3'd4,
    REG_LOWER_LIMIT = 3'd5,
    REG_LOOP_MODE   = 3'd6
  } reg_idx_e;

endpackage

[rtl/pid_controller_dual_mode_core.sv]
// Top level of the dual-mode PID controller: error history, gain products, integral and clamp.
//
//   channel | direction | handshake                    | payload
//   in      | input     | in_valid_i / in_stall_o      | opcode_i, measurement_i
//   out     | output    | out_valid_o / out_stall_i    | drive_o, clamped_o
//   cfg     | input     | cfg_we_i (no handshake back) | cfg_index_i, cfg_data_i
//
// One word is taken per cycle while in_stall_o is low. A word passes the input register,
// the product register and the result register, in that order.
// The integral and last drive live next to the result register, so the feedback loop
// closes there. A clear word leaves no result. Reset empties all stages and loads
// the register defaults. A stalled output holds its word while the two stages behind it
// still fill, then in_stall_o rises.
`timescale 1ns / 1ps

module pid_controller_dual_mode_core #(
  parameter int SampleWidth  = pidc_pkg::SAMPLE_WIDTH,
  parameter int GainFracBits = pidc_pkg::GAIN_FRAC_BITS,
  localparam int CfgW = (SampleWidth > pidc_pkg::GAIN_W) ? SampleWidth : pidc_pkg::GAIN_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CfgW-1:0]                     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic signed [SampleWidth-1:0]       measurement_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pidc_pkg::DRIVE_W-1:0] drive_o,
  output logic                                clamped_o
);

  localparam int GainW   = pidc_pkg::GAIN_W;
  localparam int LimW    = pidc_pkg::LIMIT_W;
  localparam int IntegW  = pidc_pkg::INTEG_W;
  localparam int DriveW  = pidc_pkg::DRIVE_W;
  localparam int EW      = SampleWidth + 1;
  localparam int DW      = EW + 2;
  localparam int ProdW   = GainW + DW;
  localparam int ScaledW = LimW + GainFracBits;
  localparam int PW      = ProdW + 2;
  localparam int AW      = ((PW > IntegW) ? PW : IntegW) + 2;

  localparam logic signed [AW-1:0] IntegMax = {{(AW-IntegW+1){1'b0}}, {(IntegW-1){1'b1}}};
  localparam logic signed [AW-1:0] IntegMin = ~IntegMax;

  // configuration registers
  logic signed [GainW-1:0]       gain_p_q, gain_i_q, gain_d_q;
  logic signed [SampleWidth-1:0] target_q;
  logic signed [LimW-1:0]        upper_q, lower_q;
  pidc_pkg::mode_e               mode_q;
  logic                          mode_clr;

  assign mode_clr = cfg_we_i && (cfg_index_i == pidc_pkg::REG_LOOP_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      target_q <= '0;
      upper_q  <= pidc_pkg::UPPER_RST;
      lower_q  <= pidc_pkg::LOWER_RST;
      mode_q   <= pidc_pkg::MODE_POSITION;
    end else if (cfg_we_i) begin
      unique case (pidc_pkg::reg_idx_e'(cfg_index_i))
        pidc_pkg::REG_GAIN_P:      gain_p_q <= cfg_data_i[GainW-1:0];
        pidc_pkg::REG_GAIN_I:      gain_i_q <= cfg_data_i[GainW-1:0];
        pidc_pkg::REG_GAIN_D:      gain_d_q <= cfg_data_i[GainW-1:0];
        pidc_pkg::REG_TARGET:      target_q <= cfg_data_i[SampleWidth-1:0];
        pidc_pkg::REG_UPPER_LIMIT: upper_q  <= cfg_data_i[LimW-1:0];
        pidc_pkg::REG_LOWER_LIMIT: lower_q  <= cfg_data_i[LimW-1:0];
        pidc_pkg::REG_LOOP_MODE:   mode_q   <= pidc_pkg::mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // flow control
  logic s1_v_q, s2_v_q, out_v_q;
  pidc_pkg::op_e s1_op_q, s2_op_q;
  logic adv_out, s2_move, s2_free, s1_move, acc_in, emit;

  assign adv_out    = !out_v_q || !out_stall_i;
  assign s2_move    = s2_v_q && ((s2_op_q == pidc_pkg::OP_CLEAR) || adv_out);
  assign s2_free    = !s2_v_q || s2_move;
  assign s1_move    = s1_v_q && s2_free;
  assign in_stall_o = s1_v_q && !s2_free;
  assign acc_in     = in_valid_i && !in_stall_o;
  assign emit       = s2_v_q && (s2_op_q == pidc_pkg::OP_UPDATE) && adv_out;

  // error and its differences at the input
  logic signed [EW-1:0] pe_q, ppe_q, e_in;
  logic signed [DW-1:0] e_x, pe_x, ppe_x, d1_in, d2_in;

  assign e_in  = {target_q[SampleWidth-1], target_q}
               - {measurement_i[SampleWidth-1], measurement_i};
  assign e_x   = {{2{e_in[EW-1]}}, e_in};
  assign pe_x  = {{2{pe_q[EW-1]}}, pe_q};
  assign ppe_x = {{2{ppe_q[EW-1]}}, ppe_q};
  assign d1_in = e_x - pe_x;
  assign d2_in = e_x - (pe_x <<< 1) + ppe_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_q  <= '0;
      ppe_q <= '0;
    end else if (mode_clr) begin
      pe_q  <= '0;
      ppe_q <= '0;
    end else if (acc_in) begin
      if (pidc_pkg::op_e'(opcode_i) == pidc_pkg::OP_CLEAR) begin
        pe_q  <= '0;
        ppe_q <= '0;
      end else begin
        pe_q <= e_in;
        if (mode_q == pidc_pkg::MODE_INCREMENTAL) begin
          ppe_q <= pe_q;
        end
      end
    end
  end

  // input register
  logic signed [EW-1:0] s1_e_q;
  logic signed [DW-1:0] s1_d1_q, s1_d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s1_op_q <= pidc_pkg::OP_UPDATE;
    end else if (!in_stall_o) begin
      s1_v_q  <= in_valid_i;
      s1_op_q <= pidc_pkg::op_e'(opcode_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      s1_e_q  <= e_in;
      s1_d1_q <= d1_in;
      s1_d2_q <= d2_in;
    end
  end

  // gain products
  logic signed [DW-1:0]    m1, m2, m3;
  logic signed [ProdW-1:0] p1_d, p2_d, p3_d;
  logic signed [ProdW-1:0] s2_t1_q, s2_t2_q, s2_t3_q;

  assign m2   = {{2{s1_e_q[EW-1]}}, s1_e_q};
  assign m1   = (mode_q == pidc_pkg::MODE_POSITION) ? m2 : s1_d1_q;
  assign m3   = (mode_q == pidc_pkg::MODE_POSITION) ? s1_d1_q : s1_d2_q;
  assign p1_d = $signed({{DW{gain_p_q[GainW-1]}}, gain_p_q})
              * $signed({{GainW{m1[DW-1]}}, m1});
  assign p2_d = $signed({{DW{gain_i_q[GainW-1]}}, gain_i_q})
              * $signed({{GainW{m2[DW-1]}}, m2});
  assign p3_d = $signed({{DW{gain_d_q[GainW-1]}}, gain_d_q})
              * $signed({{GainW{m3[DW-1]}}, m3});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      s2_op_q <= pidc_pkg::OP_UPDATE;
    end else if (s2_free) begin
      s2_v_q  <= s1_v_q;
      s2_op_q <= s1_op_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_t1_q <= p1_d;
      s2_t2_q <= p2_d;
      s2_t3_q <= p3_d;
    end
  end

  // integral, clamp and result
  logic signed [IntegW-1:0]  integ_q;
  logic signed [ScaledW-1:0] prev_drive_q;
  logic signed [AW-1:0] t1a, t2a, t3a, integ_a, pdrv_a, hi_a, lo_a;
  logic signed [AW-1:0] pd, cand_raw, cand, trial, alt, inc, cl_in, cl_out, res;
  logic in_limits, cl_hi, cl_lo, hit, commit;

  assign t1a     = {{(AW-ProdW){s2_t1_q[ProdW-1]}}, s2_t1_q};
  assign t2a     = {{(AW-ProdW){s2_t2_q[ProdW-1]}}, s2_t2_q};
  assign t3a     = {{(AW-ProdW){s2_t3_q[ProdW-1]}}, s2_t3_q};
  assign integ_a = {{(AW-IntegW){integ_q[IntegW-1]}}, integ_q};
  assign pdrv_a  = {{(AW-ScaledW){prev_drive_q[ScaledW-1]}}, prev_drive_q};
  assign hi_a    = {{(AW-ScaledW){upper_q[LimW-1]}}, upper_q, {GainFracBits{1'b0}}};
  assign lo_a    = {{(AW-ScaledW){lower_q[LimW-1]}}, lower_q, {GainFracBits{1'b0}}};

  assign pd        = t1a + t3a;
  assign cand_raw  = integ_a + t2a;
  assign cand      = (cand_raw > IntegMax) ? IntegMax :
                     (cand_raw < IntegMin) ? IntegMin : cand_raw;
  assign trial     = pd + cand;
  assign alt       = pd + integ_a;
  assign inc       = pdrv_a + t1a + t2a + t3a;
  assign in_limits = (trial <= hi_a) && (trial >= lo_a);

  assign cl_in  = (mode_q == pidc_pkg::MODE_POSITION) ? alt : inc;
  assign cl_hi  = cl_in > hi_a;
  assign cl_lo  = cl_in < lo_a;
  assign cl_out = cl_hi ? hi_a : (cl_lo ? lo_a : cl_in);

  always_comb begin
    if (mode_q == pidc_pkg::MODE_POSITION) begin
      res    = in_limits ? trial : cl_out;
      hit    = !in_limits;
      commit = in_limits;
    end else begin
      res    = cl_out;
      hit    = cl_hi || cl_lo;
      commit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q      <= '0;
      prev_drive_q <= '0;
    end else if (mode_clr || (s2_move && (s2_op_q == pidc_pkg::OP_CLEAR))) begin
      integ_q      <= '0;
      prev_drive_q <= '0;
    end else if (emit) begin
      prev_drive_q <= res[ScaledW-1:0];
      if (commit) begin
        integ_q <= cand[IntegW-1:0];
      end
    end
  end

  // output register
  logic signed [DriveW-1:0] drive_q;
  logic                     clamped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv_out) begin
      out_v_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      drive_q   <= res[DriveW-1:0];
      clamped_q <= hit;
    end
  end

  assign out_valid_o = out_v_q;
  assign drive_o     = drive_q;
  assign clamped_o   = clamped_q;

endmodule

[rtl/pidc_checker.sv]
// Port-level checks of the dual-mode PID controller and their binding to the top level.
`timescale 1ns / 1ps

module pidc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                opcode_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [pidc_pkg::DRIVE_W-1:0] drive_o,
  input logic                                clamped_o
);

  // hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o) && $stable(clamped_o))
    else $error("stalled result word changed");

  // leave reset empty and ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty after reset");

  // never stall the input while the output drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output can move");

  // deliver a taken update word to the output when the output is not stalled meanwhile
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (opcode_i == pidc_pkg::OP_UPDATE))
      ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("update word did not reach the output");

endmodule

bind pid_controller_dual_mode_core pidc_checker u_pidc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .opcode_i    (opcode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_o     (drive_o),
  .clamped_o   (clamped_o)
);

[dv/tb.sv]
// Testbench for the dual-mode PID controller: directed and random samples checked by a predictor.
`timescale 1ns / 1ps

module tb;

  localparam logic [pidc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam longint INTEG_HI = (longint'(1) <<< (pidc_pkg::INTEG_W - 1)) - 1;
  localparam longint INTEG_LO = -(longint'(1) <<< (pidc_pkg::INTEG_W - 1));
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_WORDS = 66;

  typedef logic [pidc_pkg::GAIN_W-1:0]              cfg_word_t;
  typedef logic signed [pidc_pkg::SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    logic signed [pidc_pkg::DRIVE_W-1:0] drive;
    logic                                clamped;
  } drive_word_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_we = 1'b0;
  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  cfg_word_t                            cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  pidc_pkg::op_e                        opcode = pidc_pkg::OP_UPDATE;
  sample_t                              measurement = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic signed [pidc_pkg::DRIVE_W-1:0]  drive;
  logic                                 clamped;

  pid_controller_dual_mode_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .measurement_i (measurement),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .drive_o       (drive),
    .clamped_o     (clamped)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state and register copies
  logic signed [pidc_pkg::GAIN_W-1:0]    gain_p = '0;
  logic signed [pidc_pkg::GAIN_W-1:0]    gain_i = '0;
  logic signed [pidc_pkg::GAIN_W-1:0]    gain_d = '0;
  sample_t                               setpoint = '0;
  logic signed [pidc_pkg::LIMIT_W-1:0]   limit_hi = pidc_pkg::UPPER_RST;
  logic signed [pidc_pkg::LIMIT_W-1:0]   limit_lo = pidc_pkg::LOWER_RST;
  pidc_pkg::mode_e                       loop_mode = pidc_pkg::MODE_POSITION;
  logic signed [pidc_pkg::SAMPLE_WIDTH:0] err_last = '0;
  logic signed [pidc_pkg::SAMPLE_WIDTH:0] err_last2 = '0;
  logic signed [pidc_pkg::INTEG_W-1:0]   integ_acc = '0;
  logic signed [pidc_pkg::DRIVE_W-1:0]   drive_last = '0;

  drive_word_t pending_drives[$];
  int          error_count = 0;
  bit          sender_idle = 1'b1;
  bit          receiver_idle = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_history();
    err_last = '0;
    err_last2 = '0;
    integ_acc = '0;
    drive_last = '0;
  endfunction

  function automatic drive_word_t predict_drive(sample_t meas);
    longint scale, hi, lo, e, pd, cand, trial, delta, value;
    logic   hit;
    drive_word_t res;
    scale = longint'(1) <<< pidc_pkg::GAIN_FRAC_BITS;
    hi = longint'(limit_hi) * scale;
    lo = longint'(limit_lo) * scale;
    e = longint'(setpoint) - longint'(meas);
    hit = 1'b0;
    if (loop_mode == pidc_pkg::MODE_POSITION) begin
      pd = longint'(gain_p) * e + longint'(gain_d) * (e - longint'(err_last));
      cand = longint'(integ_acc) + longint'(gain_i) * e;
      if (cand > INTEG_HI) cand = INTEG_HI;
      if (cand < INTEG_LO) cand = INTEG_LO;
      trial = pd + cand;
      if (trial <= hi && trial >= lo) begin
        integ_acc = cand[pidc_pkg::INTEG_W-1:0];
        value = trial;
      end else begin
        hit = 1'b1;
        value = pd + longint'(integ_acc);
      end
    end else begin
      delta = longint'(gain_p) * (e - longint'(err_last)) + longint'(gain_i) * e
            + longint'(gain_d) * (e - 2 * longint'(err_last) + longint'(err_last2));
      value = longint'(drive_last) + delta;
      err_last2 = err_last;
    end
    if (value > hi) begin
      value = hi;
      hit = 1'b1;
    end else if (value < lo) begin
      value = lo;
      hit = 1'b1;
    end
    err_last = e[pidc_pkg::SAMPLE_WIDTH:0];
    drive_last = value[pidc_pkg::DRIVE_W-1:0];
    res.drive = value[pidc_pkg::DRIVE_W-1:0];
    res.clamped = hit;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_word(pidc_pkg::op_e op, sample_t meas);
    int gap;
    gap = 0;
    if (sender_idle && $urandom_range(0, 99) < 30) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    opcode <= op;
    measurement <= meas;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (op == pidc_pkg::OP_CLEAR) clear_history();
    else pending_drives.push_back(predict_drive(meas));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [pidc_pkg::CFG_IDX_W-1:0] idx, cfg_word_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      pidc_pkg::REG_GAIN_P:      gain_p = data;
      pidc_pkg::REG_GAIN_I:      gain_i = data;
      pidc_pkg::REG_GAIN_D:      gain_d = data;
      pidc_pkg::REG_TARGET:      setpoint = data;
      pidc_pkg::REG_UPPER_LIMIT: limit_hi = data;
      pidc_pkg::REG_LOWER_LIMIT: limit_lo = data;
      pidc_pkg::REG_LOOP_MODE: begin
        loop_mode = pidc_pkg::mode_e'(data[0]);
        clear_history();
      end
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(int kp, int ki, int kd, int sp, int hi, int lo,
                           pidc_pkg::mode_e m);
    write_reg(pidc_pkg::REG_GAIN_P, cfg_word_t'(kp));
    write_reg(pidc_pkg::REG_GAIN_I, cfg_word_t'(ki));
    write_reg(pidc_pkg::REG_GAIN_D, cfg_word_t'(kd));
    write_reg(pidc_pkg::REG_TARGET, cfg_word_t'(sp));
    write_reg(pidc_pkg::REG_UPPER_LIMIT, cfg_word_t'(hi));
    write_reg(pidc_pkg::REG_LOWER_LIMIT, cfg_word_t'(lo));
    write_reg(pidc_pkg::REG_LOOP_MODE, {{(pidc_pkg::GAIN_W-1){1'b0}}, m});
  endtask

  function automatic cfg_word_t rand_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return cfg_word_t'(int'($urandom_range(0, 1024)) - 512);
    if (r < 85) return cfg_word_t'($urandom());
    if (r < 90) return 16'h7fff;
    if (r < 95) return 16'h8000;
    return 16'h0100;
  endfunction

  function automatic sample_t rand_meas();
    int r, off, m;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      off = $urandom_range(0, 400);
      m = setpoint + off - 200;
      if (m > 32767) m = 32767;
      if (m < -32768) m = -32768;
      return sample_t'(m);
    end
    if (r < 90) return sample_t'($urandom());
    if (r < 95) return 16'sh7fff;
    return 16'sh8000;
  endfunction

  // Output side: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (receiver_idle && $urandom_range(0, 99) < 25) begin
      stall_left <= pick_gap() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_drive
    drive_word_t want;
    if (rst_ni && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_drives.size() == 0) begin
        report_mismatch($sformatf("unexpected word drive=%0d clamped=%0b", drive, clamped));
      end else begin
        want = pending_drives.pop_front();
        if (drive !== want.drive)
          report_mismatch($sformatf("drive %0d, want %0d", drive, want.drive));
        if (clamped !== want.clamped)
          report_mismatch($sformatf("clamped %0b, want %0b", clamped, want.clamped));
      end
    end
  end

  task automatic test_reset_state();
    send_word(pidc_pkg::OP_UPDATE, 16'sd0);
    send_word(pidc_pkg::OP_UPDATE, -16'sd32768);
    settle();
  endtask

  task automatic test_position_extremes();
    configure(256, 16, 64, 0, 32767, -32768, pidc_pkg::MODE_POSITION);
    send_word(pidc_pkg::OP_UPDATE, 16'sd32767);
    send_word(pidc_pkg::OP_UPDATE, -16'sd32768);
    send_word(pidc_pkg::OP_UPDATE, 16'sd1);
    settle();
    configure(32767, 32767, -32768, 32767, 32767, -32768, pidc_pkg::MODE_POSITION);
    send_word(pidc_pkg::OP_UPDATE, -16'sd32768);
    send_word(pidc_pkg::OP_UPDATE, -16'sd32768);
    send_word(pidc_pkg::OP_UPDATE, 16'sd32767);
    settle();
  endtask

  task automatic test_incremental_extremes();
    configure(-32768, 32767, 32767, -32768, 100, -100, pidc_pkg::MODE_INCREMENTAL);
    send_word(pidc_pkg::OP_UPDATE, 16'sd32767);
    send_word(pidc_pkg::OP_UPDATE, -16'sd32768);
    send_word(pidc_pkg::OP_UPDATE, 16'sd0);
    settle();
    configure(300, -20, 100, 50, 32767, -32768, pidc_pkg::MODE_INCREMENTAL);
    send_word(pidc_pkg::OP_UPDATE, 16'sd40);
    send_word(pidc_pkg::OP_UPDATE, 16'sd60);
    settle();
  endtask

  task automatic test_inverted_limits();
    configure(256, 128, 0, 0, -50, 50, pidc_pkg::MODE_POSITION);
    send_word(pidc_pkg::OP_UPDATE, 16'sd10);
    send_word(pidc_pkg::OP_UPDATE, -16'sd200);
    settle();
    write_reg(pidc_pkg::REG_LOOP_MODE, cfg_word_t'(pidc_pkg::MODE_INCREMENTAL));
    send_word(pidc_pkg::OP_UPDATE, 16'sd10);
    send_word(pidc_pkg::OP_UPDATE, -16'sd300);
    settle();
  endtask

  task automatic test_clear_and_rewrite();
    configure(256, 64, 32, 100, 1000, -1000, pidc_pkg::MODE_INCREMENTAL);
    send_word(pidc_pkg::OP_UPDATE, 16'sd90);
    send_word(pidc_pkg::OP_CLEAR, 16'sd0);
    send_word(pidc_pkg::OP_UPDATE, 16'sd70);
    settle();
    write_reg(pidc_pkg::REG_LOOP_MODE, cfg_word_t'(pidc_pkg::MODE_INCREMENTAL));
    write_reg(REG_SPARE, 16'hffff);
    send_word(pidc_pkg::OP_UPDATE, 16'sd80);
    settle();
    write_reg(pidc_pkg::REG_LOOP_MODE, cfg_word_t'(pidc_pkg::MODE_POSITION));
    send_word(pidc_pkg::OP_UPDATE, 16'sd95);
    send_word(pidc_pkg::OP_CLEAR, -16'sd1);
    send_word(pidc_pkg::OP_UPDATE, 16'sd95);
    settle();
  endtask

  task automatic test_random_phases();
    int r, hi, lo, sp;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      sender_idle = (ph % 5 != 0);
      receiver_idle = (ph % 5 != 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        hi = $urandom_range(50, 5000);
        lo = -$urandom_range(50, 5000);
      end else if (r < 85) begin
        hi = 32767;
        lo = -32768;
      end else begin
        hi = $urandom_range(0, 65535) - 32768;
        lo = $urandom_range(0, 65535) - 32768;
      end
      sp = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2000) - 1000
                                        : $urandom_range(0, 65535) - 32768;
      configure(rand_gain(), rand_gain(), rand_gain(), sp, hi, lo,
                pidc_pkg::mode_e'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, cfg_word_t'($urandom()));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) < 4) send_word(pidc_pkg::OP_CLEAR, sample_t'($urandom()));
        else send_word(pidc_pkg::OP_UPDATE, rand_meas());
      end
    end
    settle();
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    configure(200, 10, 50, 0, 2000, -2000, pidc_pkg::MODE_POSITION);
    sender_idle = 1'b0;
    hold_req = ~hold_req;
    for (int n = 0; n < 40; n++) send_word(pidc_pkg::OP_UPDATE, rand_meas());
    settle();
    sender_idle = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_state();
    test_position_extremes();
    test_incremental_extremes();
    test_inverted_limits();
    test_clear_and_rewrite();
    test_random_phases();
    test_backpressure();
    settle();
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
